### rtl/round_robin_slot_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Round-robin slot scheduler: assertion macros
// Shared checking macros, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("round-robin slot scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("round-robin slot scheduler check failed");

`endif

### rtl/rrss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin slot scheduler package
// Sizes, codes and the structures passed between the sequencer and the cells.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SLOT_IN_W  = 6;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned S_DATA_W   = 40;
  localparam int unsigned M_DATA_W   = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_KILL   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DONE     = 3'd0,
    KIND_ERROR    = 3'd1,
    KIND_REAPED   = 3'd2,
    KIND_SWITCHED = 3'd3,
    KIND_KEPT     = 3'd4,
    KIND_NONE     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CREATE,
    OP_START,
    OP_STOP,
    OP_KILL,
    OP_LOAD,
    OP_STEP,
    OP_DROP
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PEEK,
    S_WALK,
    S_NONE
  } state_e;

  typedef struct packed {
    cell_op_e              op;
    logic [SLOT_W-1:0]     slot;
    logic [BASE_W-1:0]     base;
  } cell_cmd_t;

  typedef struct packed {
    logic                  hit;
    logic                  die;
    logic                  active;
    logic [BASE_W-1:0]     base;
  } cell_view_t;

  typedef struct packed {
    logic                  taken;
    logic [SLOT_W-1:0]     free_slot;
    logic [1:0]            act_cnt;
    cell_view_t            view;
  } cell_chain_t;

endpackage

### rtl/round_robin_slot_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin slot scheduler
// A ring of slot cells driven by one sequencer, with a registered result port.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Create, start, stop, kill, bad and
// out-of-range read commands give their single result from the decode
// state; an in-range read and a tick with fewer than two active slots give
// it from the peek state after it. A tick walk moves a token one cell round
// the ring per cycle while the output is free; each reaped slot gives one
// result, and if the whole pass is reaped the none-active result follows.
// A result stalled at the output holds the walk where it is. No clearing
// pass is needed after reset: every cell resets to a free, idle slot.
module round_robin_slot_scheduler_unit
  import rrss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // slot [5:0], block_base [37:6]
  input  logic [CMD_W-1:0]    s_axis_tuser_i,   // command [2:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,   // slot_out [3:0], base_out [35:4],
                                                // tick_count [67:36]
  output logic [KIND_W-1:0]   m_axis_tuser_o,   // kind [2:0]
  output logic                m_axis_tlast_o
);

  cell_cmd_t        cell_cmd;
  cell_chain_t      chain_w [SLOTS+1];
  logic [SLOTS-1:0] pass_w;

  assign chain_w[0] = '0;

  rrss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_o           (cell_cmd),
    .chain_i         (chain_w[SLOTS])
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    // The walk token enters each cell from the one before it in the ring.
    rrss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SLOT_W'(g)),
      .cmd_i   (cell_cmd),
      .chain_i (chain_w[g]),
      .chain_o (chain_w[g+1]),
      .pass_i  (pass_w[(g + SLOTS - 1) % SLOTS]),
      .pass_o  (pass_w[g])
    );
  end

endmodule

### rtl/rrss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin slot scheduler: slot cell
// Holds one slot's base and marks, carries the walk token round the ring and
// extends the free-slot, active-count and token-view chains.
// ----------------------------------------------------------------------------
module rrss_cell
  import rrss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] idx_i,
  input  cell_cmd_t         cmd_i,
  input  cell_chain_t       chain_i,
  output cell_chain_t       chain_o,
  input  logic              pass_i,
  output logic              pass_o
);

  logic [BASE_W-1:0] base_q, base_d;
  logic              active_q, active_d;
  logic              die_q, die_d;
  logic              tok_q, tok_d;
  logic              sel;
  logic              free;
  logic              win;

  assign sel  = (cmd_i.slot == idx_i);
  assign free = (base_q == '0);
  // This cell is the first free slot when no earlier cell was free.
  assign win  = free && !chain_i.taken;

  always_comb begin
    chain_o.taken     = chain_i.taken | free;
    chain_o.free_slot = win ? idx_i : chain_i.free_slot;
    if (active_q && (chain_i.act_cnt != 2'd2)) begin
      chain_o.act_cnt = chain_i.act_cnt + 2'd1;
    end else begin
      chain_o.act_cnt = chain_i.act_cnt;
    end
    chain_o.view.hit    = chain_i.view.hit | tok_q;
    chain_o.view.die    = chain_i.view.die | (tok_q & die_q);
    chain_o.view.active = chain_i.view.active | (tok_q & active_q);
    chain_o.view.base   = chain_i.view.base | ({BASE_W{tok_q}} & base_q);
  end

  // The token moves on from a slot that is reaped or idle.
  assign pass_o = tok_q & (die_q | !active_q);

  always_comb begin
    base_d   = base_q;
    active_d = active_q;
    die_d    = die_q;
    tok_d    = tok_q;
    case (cmd_i.op)
      OP_CREATE: begin
        if (win) begin
          base_d = cmd_i.base;
        end
      end
      OP_START: begin
        if (sel) begin
          active_d = 1'b1;
        end
      end
      OP_STOP: begin
        if (sel) begin
          active_d = 1'b0;
        end
      end
      OP_KILL: begin
        if (sel) begin
          die_d = 1'b1;
        end
      end
      OP_LOAD: begin
        tok_d = sel;
      end
      OP_STEP: begin
        tok_d = pass_i;
        if (tok_q && die_q) begin
          base_d   = '0;
          active_d = 1'b0;
          die_d    = 1'b0;
        end
      end
      OP_DROP: begin
        tok_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      active_q <= 1'b0;
      die_q    <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      base_q   <= base_d;
      active_q <= active_d;
      die_q    <= die_d;
      tok_q    <= tok_d;
    end
  end

endmodule

### rtl/rrss_ctrl.sv
`timescale 1ns / 1ps
`include "round_robin_slot_scheduler_unit_defines.svh"
// ----------------------------------------------------------------------------
// Round-robin slot scheduler: sequencer
// Takes items, drives the cell row, steps the tick walk and holds the
// registered result stage.
// ----------------------------------------------------------------------------
module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // slot [5:0], block_base [37:6]
  input  logic [CMD_W-1:0]    s_axis_tuser_i,   // command [2:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,   // slot_out [3:0], base_out [35:4],
                                                // tick_count [67:36]
  output logic [KIND_W-1:0]   m_axis_tuser_o,   // kind [2:0]
  output logic                m_axis_tlast_o,
  output cell_cmd_t           cmd_o,
  input  cell_chain_t         chain_i
);

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [SLOT_IN_W-1:0]  slot_q;
  logic [BASE_W-1:0]     base_q;
  logic [TICK_W-1:0]     ticks_q;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [SLOT_W-1:0]     idx_q, idx_d;
  logic [SLOT_W-1:0]     step_q, step_d;
  kind_e                 pk_kind_q, pk_kind_d;
  logic [SLOT_OUT_W-1:0] pk_slot_q, pk_slot_d;

  logic                  m_valid_q;
  kind_e                 m_kind_q;
  logic [SLOT_OUT_W-1:0] m_slot_q;
  logic [BASE_W-1:0]     m_base_q;
  logic [TICK_W-1:0]     m_tick_q;
  logic                  m_last_q;

  logic                  accept;
  logic                  out_free;
  logic                  emit;
  kind_e                 e_kind;
  logic [SLOT_OUT_W-1:0] e_slot;
  logic [BASE_W-1:0]     e_base;
  logic                  e_last;
  logic                  slot_oob;
  logic [SLOT_W-1:0]     slot_tgt;
  logic [SLOT_W-1:0]     cur_next;
  logic [SLOT_W-1:0]     idx_next;
  logic                  last_step;
  logic                  few_active;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign slot_oob   = ({1'b0, slot_q} >= (SLOT_IN_W + 1)'(SLOTS));
  assign slot_tgt   = slot_q[SLOT_W-1:0];
  assign cur_next   = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
  assign idx_next   = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign last_step  = (step_q == SLOT_W'(SLOTS - 1));
  assign few_active = (chain_i.act_cnt != 2'd2);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (out_free) begin
          case (cmd_q)
            CMD_TICK: state_d = few_active ? S_PEEK : S_WALK;
            CMD_READ: state_d = slot_oob ? S_IDLE : S_PEEK;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PEEK: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (out_free) begin
          if (chain_i.view.die) begin
            state_d = last_step ? S_NONE : S_WALK;
          end else if (chain_i.view.active || last_step) begin
            state_d = S_IDLE;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: cell commands, results and walk bookkeeping.
  always_comb begin
    emit      = 1'b0;
    e_kind    = KIND_ERROR;
    e_slot    = '0;
    e_base    = '0;
    e_last    = 1'b0;
    cmd_o.op   = OP_IDLE;
    cmd_o.slot = slot_tgt;
    cmd_o.base = base_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    step_d    = step_q;
    pk_kind_d = pk_kind_q;
    pk_slot_d = pk_slot_q;
    case (state_q)
      S_DECODE: begin
        if (out_free) begin
          case (cmd_q)
            CMD_TICK: begin
              cmd_o.op = OP_LOAD;
              if (few_active) begin
                cmd_o.slot = cur_q;
                pk_kind_d  = KIND_KEPT;
                pk_slot_d  = SLOT_OUT_W'(cur_q);
              end else begin
                cmd_o.slot = cur_next;
                idx_d      = cur_next;
                step_d     = '0;
              end
            end
            CMD_CREATE: begin
              emit   = 1'b1;
              e_last = 1'b1;
              if ((base_q != '0) && chain_i.taken) begin
                cmd_o.op = OP_CREATE;
                e_kind   = KIND_DONE;
                e_slot   = SLOT_OUT_W'(chain_i.free_slot);
                e_base   = base_q;
              end
            end
            CMD_START, CMD_STOP, CMD_KILL: begin
              emit   = 1'b1;
              e_last = 1'b1;
              e_slot = SLOT_OUT_W'(slot_q);
              if (!slot_oob) begin
                e_kind = KIND_DONE;
                case (cmd_q)
                  CMD_START: cmd_o.op = OP_START;
                  CMD_STOP:  cmd_o.op = OP_STOP;
                  default:   cmd_o.op = OP_KILL;
                endcase
              end
            end
            CMD_READ: begin
              if (slot_oob) begin
                emit   = 1'b1;
                e_last = 1'b1;
                e_slot = SLOT_OUT_W'(slot_q);
              end else begin
                cmd_o.op  = OP_LOAD;
                pk_kind_d = KIND_DONE;
                pk_slot_d = SLOT_OUT_W'(slot_q);
              end
            end
            default: begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (out_free) begin
          emit     = 1'b1;
          e_kind   = pk_kind_q;
          e_slot   = pk_slot_q;
          e_base   = chain_i.view.base;
          e_last   = 1'b1;
          cmd_o.op = OP_DROP;
        end
      end
      S_WALK: begin
        if (out_free) begin
          if (chain_i.view.die) begin
            emit     = 1'b1;
            e_kind   = KIND_REAPED;
            e_slot   = SLOT_OUT_W'(idx_q);
            e_base   = chain_i.view.base;
            cmd_o.op = OP_STEP;
            idx_d    = idx_next;
            step_d   = step_q + 1'b1;
          end else if (chain_i.view.active) begin
            emit     = 1'b1;
            e_kind   = KIND_SWITCHED;
            e_slot   = SLOT_OUT_W'(idx_q);
            e_base   = chain_i.view.base;
            e_last   = 1'b1;
            cmd_o.op = OP_DROP;
            cur_d    = idx_q;
          end else if (last_step) begin
            // A whole pass found nothing to run.
            emit     = 1'b1;
            e_kind   = KIND_NONE;
            e_slot   = SLOT_OUT_W'(cur_q);
            e_last   = 1'b1;
            cmd_o.op = OP_DROP;
          end else begin
            cmd_o.op = OP_STEP;
            idx_d    = idx_next;
            step_d   = step_q + 1'b1;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          emit     = 1'b1;
          e_kind   = KIND_NONE;
          e_slot   = SLOT_OUT_W'(cur_q);
          e_last   = 1'b1;
          cmd_o.op = OP_DROP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ticks_q   <= '0;
      cur_q     <= '0;
      idx_q     <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      if (accept && (s_axis_tuser_i == CMD_TICK)) begin
        ticks_q <= ticks_q + 1'b1;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser_i;
      slot_q <= s_axis_tdata_i[SLOT_IN_W-1:0];
      base_q <= s_axis_tdata_i[SLOT_IN_W +: BASE_W];
    end
    pk_kind_q <= pk_kind_d;
    pk_slot_q <= pk_slot_d;
    if (emit) begin
      m_kind_q <= e_kind;
      m_slot_q <= e_slot;
      m_base_q <= e_base;
      m_tick_q <= ticks_q;
      m_last_q <= e_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - SLOT_OUT_W - BASE_W - TICK_W){1'b0}},
                            m_tick_q, m_base_q, m_slot_q};

  `RRSS_ASSERT_IMP(a_walk_has_token, state_q == S_WALK, chain_i.view.hit)
  `RRSS_ASSERT_IMP(a_peek_has_token, state_q == S_PEEK, chain_i.view.hit)
  `RRSS_ASSERT_NXT(a_last_ends_item, emit && e_last, state_q == S_IDLE)
  `RRSS_ASSERT_NXT(a_switch_moves_cur, emit && (e_kind == KIND_SWITCHED), cur_q == $past(idx_q))

endmodule
